// ===== hdl/ddd_pkg.sv =====
package ddd_pkg;

   // field widths
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int COUNT_W  = 22;
   localparam int STATUS_W = 2;
   localparam int QUO_W    = 8;

   // valid year range
   localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
   localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

   // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for every 14-bit x
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

   // month codes used by the leap rule
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNORDERED = 2'd2;

   // one date after the year split stage
   typedef struct packed {
      logic [YEAR_W-1:0]  p;
      logic [QUO_W-1:0]   qp;
      logic               c100;
      logic [1:0]         qy_lo;
      logic [1:0]         y_lo;
      logic               year_ok;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } split_type;

   // one date after the serial stage
   typedef struct packed {
      logic [COUNT_W-1:0] serial;
      logic               ok;
   } serial_type;

   // length of a month in a common year, 0 for codes that are no month
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days before the first of the month in a common year
   function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
      logic [8:0] s;
      case (m)
         4'd1:    s = 9'd0;
         4'd2:    s = 9'd31;
         4'd3:    s = 9'd59;
         4'd4:    s = 9'd90;
         4'd5:    s = 9'd120;
         4'd6:    s = 9'd151;
         4'd7:    s = 9'd181;
         4'd8:    s = 9'd212;
         4'd9:    s = 9'd243;
         4'd10:   s = 9'd273;
         4'd11:   s = 9'd304;
         4'd12:   s = 9'd334;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

endpackage

// ===== hdl/ddd_req_if.sv =====
interface ddd_req_if;
   logic                        valid;
   logic                        ready;
   logic [ddd_pkg::YEAR_W-1:0]  begin_year;
   logic [ddd_pkg::MONTH_W-1:0] begin_month;
   logic [ddd_pkg::DAY_W-1:0]   begin_day;
   logic [ddd_pkg::YEAR_W-1:0]  end_year;
   logic [ddd_pkg::MONTH_W-1:0] end_month;
   logic [ddd_pkg::DAY_W-1:0]   end_day;

   modport source (output valid, begin_year, begin_month, begin_day,
                   end_year, end_month, end_day, input ready);
   modport sink (input valid, begin_year, begin_month, begin_day,
                 end_year, end_month, end_day, output ready);
endinterface

// ===== hdl/ddd_rsp_if.sv =====
interface ddd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ddd_pkg::COUNT_W-1:0]  day_count;
   logic [ddd_pkg::STATUS_W-1:0] status;

   modport source (output valid, day_count, status, input ready);
   modport sink (input valid, day_count, status, output ready);
endinterface

// ===== hdl/ddd_year_split.sv =====
module ddd_year_split (
   input  logic                        clock,
   input  logic                        load,
   input  logic [ddd_pkg::YEAR_W-1:0]  year,
   input  logic [ddd_pkg::MONTH_W-1:0] month,
   input  logic [ddd_pkg::DAY_W-1:0]   day,
   output ddd_pkg::split_type          split
);

   localparam int PROD_W = ddd_pkg::YEAR_W + 13;

   logic [ddd_pkg::YEAR_W-1:0] p;
   logic [PROD_W-1:0]          prod_p;
   logic [PROD_W-1:0]          prod_y;
   logic [ddd_pkg::QUO_W-1:0]  qp;
   logic [ddd_pkg::QUO_W-1:0]  qy;
   ddd_pkg::split_type         split_in;
   ddd_pkg::split_type         split_ff;

   // completed years and their hundreds by reciprocal multiply
   always_comb begin
      p      = year - ddd_pkg::YEAR_W'(1);
      prod_p = PROD_W'(p) * PROD_W'(ddd_pkg::RECIP_100);
      prod_y = PROD_W'(year) * PROD_W'(ddd_pkg::RECIP_100);
      qp     = prod_p[ddd_pkg::RECIP_SHIFT +: ddd_pkg::QUO_W];
      qy     = prod_y[ddd_pkg::RECIP_SHIFT +: ddd_pkg::QUO_W];
   end

   // the hundreds count steps from p to year exactly at a century year
   always_comb begin
      split_in.p       = p;
      split_in.qp      = qp;
      split_in.c100    = (qy != qp);
      split_in.qy_lo   = qy[1:0];
      split_in.y_lo    = year[1:0];
      split_in.year_ok = (year >= ddd_pkg::YEAR_MIN) && (year <= ddd_pkg::YEAR_MAX);
      split_in.month   = month;
      split_in.day     = day;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         split_ff <= split_in;
      end
   end

   assign split = split_ff;

endmodule

// ===== hdl/ddd_serial.sv =====
module ddd_serial (
   input  logic               clock,
   input  logic               load,
   input  ddd_pkg::split_type split,
   output ddd_pkg::serial_type serial
);

   localparam int SUM_W = ddd_pkg::COUNT_W + 1;

   logic                        leap;
   logic [ddd_pkg::DAY_W-1:0]   len;
   logic                        extra;
   logic [SUM_W-1:0]            sum;
   ddd_pkg::serial_type         serial_in;
   ddd_pkg::serial_type         serial_ff;

   // leap rule and date check
   always_comb begin
      leap  = split.c100 ? (split.qy_lo == 2'd0) : (split.y_lo == 2'd0);
      len   = ddd_pkg::month_len(split.month);
      if ((split.month == ddd_pkg::MONTH_FEB) && leap) begin
         len = len + ddd_pkg::DAY_W'(1);
      end
      extra = (split.month > ddd_pkg::MONTH_FEB) && leap;
      serial_in.ok = split.year_ok
                     && (split.month >= ddd_pkg::MONTH_JAN)
                     && (split.month <= ddd_pkg::MONTH_DEC)
                     && (split.day != '0)
                     && (split.day <= len);
   end

   // day serial: 365 p + p/4 - p/100 + p/400 + month offset + leap day + day
   always_comb begin
      sum = SUM_W'(split.p) * SUM_W'(ddd_pkg::DAYS_PER_YEAR)
            + SUM_W'(split.p[ddd_pkg::YEAR_W-1:2])
            - SUM_W'(split.qp)
            + SUM_W'(split.qp[ddd_pkg::QUO_W-1:2])
            + SUM_W'(ddd_pkg::month_start(split.month))
            + SUM_W'(extra)
            + SUM_W'(split.day);
      serial_in.serial = sum[ddd_pkg::COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         serial_ff <= serial_in;
      end
   end

   assign serial = serial_ff;

endmodule

// ===== hdl/date_difference_days_core.sv =====
// channel   | dir | signals
// ----------+-----+------------------------------------------------------------
// req_chan  | in  | valid, ready, begin/end year (14b), month (4b), day (5b)
// rsp_chan  | out | valid, ready, day_count (22b), status (2b)
//
// one transaction per cycle sustained while rsp_chan is ready; four register stages
// from input capture to the result register
// stages: input capture, year split (reciprocal multiplies), day serial, compare
// reset (synchronous) clears the stage valid bits only
// a stall on rsp_chan holds each occupied stage with no empty stage after it; the others still move on and fill
module date_difference_days_core (
   input  logic clock,
   input  logic reset,
   ddd_req_if.sink   req_chan,
   ddd_rsp_if.source rsp_chan
);

   logic [3:0] valid_ff;
   logic [3:0] valid_in;
   logic [3:0] load;

   logic [ddd_pkg::YEAR_W-1:0]  by_ff, ey_ff;
   logic [ddd_pkg::MONTH_W-1:0] bm_ff, em_ff;
   logic [ddd_pkg::DAY_W-1:0]   bd_ff, ed_ff;

   ddd_pkg::split_type  split_b, split_e;
   ddd_pkg::serial_type serial_b, serial_e;

   logic [ddd_pkg::COUNT_W-1:0]  count_in, count_ff;
   logic [ddd_pkg::STATUS_W-1:0] status_in, status_ff;

   // a stage loads when it is empty or the next stage loads
   always_comb begin
      load[3] = !valid_ff[3] || rsp_chan.ready;
      load[2] = !valid_ff[2] || load[3];
      load[1] = !valid_ff[1] || load[2];
      load[0] = !valid_ff[0] || load[1];
      valid_in[0] = load[0] ? req_chan.valid : valid_ff[0];
      valid_in[1] = load[1] ? valid_ff[0]    : valid_ff[1];
      valid_in[2] = load[2] ? valid_ff[1]    : valid_ff[2];
      valid_in[3] = load[3] ? valid_ff[2]    : valid_ff[3];
   end

   assign req_chan.ready = load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (load[0]) begin
         by_ff <= req_chan.begin_year;
         bm_ff <= req_chan.begin_month;
         bd_ff <= req_chan.begin_day;
         ey_ff <= req_chan.end_year;
         em_ff <= req_chan.end_month;
         ed_ff <= req_chan.end_day;
      end
   end

   // per-date lanes
   ddd_year_split u_split_b (
      .clock (clock), .load (load[1]),
      .year (by_ff), .month (bm_ff), .day (bd_ff), .split (split_b)
   );

   ddd_year_split u_split_e (
      .clock (clock), .load (load[1]),
      .year (ey_ff), .month (em_ff), .day (ed_ff), .split (split_e)
   );

   ddd_serial u_serial_b (
      .clock (clock), .load (load[2]), .split (split_b), .serial (serial_b)
   );

   ddd_serial u_serial_e (
      .clock (clock), .load (load[2]), .split (split_e), .serial (serial_e)
   );

   // compare and difference
   always_comb begin
      if (!serial_b.ok || !serial_e.ok) begin
         status_in = ddd_pkg::STATUS_INVALID;
         count_in  = '0;
      end else if (serial_b.serial >= serial_e.serial) begin
         status_in = ddd_pkg::STATUS_UNORDERED;
         count_in  = '0;
      end else begin
         status_in = ddd_pkg::STATUS_OK;
         count_in  = serial_e.serial - serial_b.serial;
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   assign rsp_chan.valid     = valid_ff[3];
   assign rsp_chan.day_count = count_ff;
   assign rsp_chan.status    = status_ff;

   // a good result always covers at least one day
   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == ddd_pkg::STATUS_OK))
      |-> (rsp_chan.day_count != '0))
      else $error("ok result with zero day count");

   // error results carry no count
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != ddd_pkg::STATUS_OK))
      |-> (rsp_chan.day_count == '0))
      else $error("error result with nonzero day count");

   // a stalled serial stage keeps its transaction
   a_serial_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && !load[3])
      |=> (valid_ff[2] && $stable(serial_b) && $stable(serial_e)))
      else $error("serial stage changed while stalled");

   // an accepted transaction always enters the capture stage
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> valid_ff[0])
      else $error("accepted transaction lost at capture");

endmodule

// ===== tb/sv/date_difference_days_core_tb.sv =====
module date_difference_days_core_tb;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 9;
   localparam int NUM_DIRECTED  = 25;
   localparam int RANDOM_ITEMS  = 830;
   localparam int HOLD_TRIGGER  = 150;
   localparam int HOLD_CYCLES   = 240;
   localparam int OPEN_CYCLES   = 100;
   localparam int DRAIN_CYCLES  = 20;
   localparam int IDLE_LIMIT    = 3000;
   localparam bit TYPED         = 1'b1;
   localparam bit MODELED       = 1'b0;

   typedef struct packed {
      logic [ddd_pkg::YEAR_W-1:0]  begin_year;
      logic [ddd_pkg::MONTH_W-1:0] begin_month;
      logic [ddd_pkg::DAY_W-1:0]   begin_day;
      logic [ddd_pkg::YEAR_W-1:0]  end_year;
      logic [ddd_pkg::MONTH_W-1:0] end_month;
      logic [ddd_pkg::DAY_W-1:0]   end_day;
   } date_pair_type;

   typedef struct packed {
      logic [ddd_pkg::COUNT_W-1:0]  day_count;
      logic [ddd_pkg::STATUS_W-1:0] status;
   } span_result_type;

   typedef struct packed {
      date_pair_type   dates;
      bit              typed;
      span_result_type span;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ddd_req_if req_chan ();
   ddd_rsp_if rsp_chan ();

   date_difference_days_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #HALF_PERIOD clock = ~clock;

   span_result_type expected_spans [$];
   int unsigned  req_accepts     = 0;
   int unsigned  mismatches      = 0;
   int unsigned  ok_count        = 0;
   int unsigned  invalid_count   = 0;
   int unsigned  unordered_count = 0;

   // directed pairs; spans typed in where obvious, the rest come from the predictor
   directed_row_type directed_rows [0:NUM_DIRECTED-1] = '{
      '{'{14'd1, 4'd1, 5'd1, 14'd1, 4'd1, 5'd2}, TYPED, '{22'd1, ddd_pkg::STATUS_OK}},
      '{'{14'd1, 4'd1, 5'd1, 14'd1, 4'd12, 5'd31}, TYPED, '{22'd364, ddd_pkg::STATUS_OK}},
      '{'{14'd1, 4'd1, 5'd1, 14'd9999, 4'd12, 5'd31}, TYPED,
        '{22'd3652058, ddd_pkg::STATUS_OK}},
      '{'{14'd9999, 4'd12, 5'd30, 14'd9999, 4'd12, 5'd31}, TYPED,
        '{22'd1, ddd_pkg::STATUS_OK}},
      '{'{14'd9999, 4'd12, 5'd31, 14'd1, 4'd1, 5'd1}, TYPED,
        '{22'd0, ddd_pkg::STATUS_UNORDERED}},
      '{'{14'd2000, 4'd2, 5'd29, 14'd2000, 4'd2, 5'd29}, TYPED,
        '{22'd0, ddd_pkg::STATUS_UNORDERED}},
      '{'{14'd2000, 4'd2, 5'd28, 14'd2000, 4'd3, 5'd1}, MODELED,
        '{22'd0, ddd_pkg::STATUS_OK}},
      '{'{14'd2000, 4'd2, 5'd29, 14'd2000, 4'd3, 5'd1}, TYPED,
        '{22'd1, ddd_pkg::STATUS_OK}},
      '{'{14'd1900, 4'd2, 5'd28, 14'd1900, 4'd3, 5'd1}, TYPED,
        '{22'd1, ddd_pkg::STATUS_OK}},
      '{'{14'd1900, 4'd2, 5'd29, 14'd1900, 4'd3, 5'd1}, TYPED,
        '{22'd0, ddd_pkg::STATUS_INVALID}},
      '{'{14'd2100, 4'd2, 5'd28, 14'd2100, 4'd3, 5'd1}, TYPED,
        '{22'd1, ddd_pkg::STATUS_OK}},
      '{'{14'd1999, 4'd12, 5'd31, 14'd2000, 4'd1, 5'd1}, TYPED,
        '{22'd1, ddd_pkg::STATUS_OK}},
      '{'{14'd1600, 4'd2, 5'd29, 14'd1700, 4'd2, 5'd28}, MODELED,
        '{22'd0, ddd_pkg::STATUS_OK}},
      '{'{14'd2004, 4'd2, 5'd29, 14'd2004, 4'd12, 5'd31}, MODELED,
        '{22'd0, ddd_pkg::STATUS_OK}},
      '{'{14'd0, 4'd1, 5'd1, 14'd1, 4'd1, 5'd1}, TYPED,
        '{22'd0, ddd_pkg::STATUS_INVALID}},
      '{'{14'd1, 4'd1, 5'd1, 14'd10000, 4'd1, 5'd1}, TYPED,
        '{22'd0, ddd_pkg::STATUS_INVALID}},
      '{'{14'd16383, 4'd15, 5'd31, 14'd16383, 4'd15, 5'd31}, TYPED,
        '{22'd0, ddd_pkg::STATUS_INVALID}},
      '{'{14'd2020, 4'd0, 5'd10, 14'd2021, 4'd1, 5'd1}, TYPED,
        '{22'd0, ddd_pkg::STATUS_INVALID}},
      '{'{14'd2020, 4'd1, 5'd10, 14'd2021, 4'd13, 5'd1}, TYPED,
        '{22'd0, ddd_pkg::STATUS_INVALID}},
      '{'{14'd2020, 4'd5, 5'd0, 14'd2021, 4'd1, 5'd1}, TYPED,
        '{22'd0, ddd_pkg::STATUS_INVALID}},
      '{'{14'd2021, 4'd4, 5'd31, 14'd2021, 4'd5, 5'd1}, TYPED,
        '{22'd0, ddd_pkg::STATUS_INVALID}},
      '{'{14'd2021, 4'd1, 5'd31, 14'd2021, 4'd12, 5'd31}, MODELED,
        '{22'd0, ddd_pkg::STATUS_OK}},
      '{'{14'd2022, 4'd2, 5'd30, 14'd2020, 4'd1, 5'd1}, TYPED,
        '{22'd0, ddd_pkg::STATUS_INVALID}},
      '{'{14'd2023, 4'd6, 5'd15, 14'd2023, 4'd6, 5'd14}, TYPED,
        '{22'd0, ddd_pkg::STATUS_UNORDERED}},
      '{'{14'd1583, 4'd10, 5'd15, 14'd2024, 4'd7, 5'd4}, MODELED,
        '{22'd0, ddd_pkg::STATUS_OK}}
   };

   // gregorian leap rule
   function automatic bit is_leap_year(input int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   // month length, 0 for a code that is no month
   function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
      int unsigned n;
      case (m)
         1, 3, 5, 7, 8, 10, 12: n = 31;
         4, 6, 9, 11:           n = 30;
         2:                     n = is_leap_year(y) ? 29 : 28;
         default:               n = 0;
      endcase
      return n;
   endfunction

   function automatic bit date_is_valid(input int unsigned y, input int unsigned m,
                                        input int unsigned d);
      return (y >= ddd_pkg::YEAR_MIN) && (y <= ddd_pkg::YEAR_MAX)
             && (d >= 1) && (d <= month_days(y, m));
   endfunction

   // day number counted from the first of january of year one
   function automatic int unsigned day_serial(input int unsigned y, input int unsigned m,
                                              input int unsigned d);
      int unsigned p;
      int unsigned s;
      p = y - 1;
      s = 365 * p + p / 4 - p / 100 + p / 400 + d;
      for (int unsigned k = 1; k < m; k++)
         s += month_days(y, k);
      return s;
   endfunction

   // expected span and status of one date pair
   function automatic span_result_type predict_span(input date_pair_type p);
      span_result_type r;
      int unsigned     sb;
      int unsigned     se;
      r.day_count = '0;
      if (!date_is_valid(p.begin_year, p.begin_month, p.begin_day) ||
          !date_is_valid(p.end_year, p.end_month, p.end_day)) begin
         r.status = ddd_pkg::STATUS_INVALID;
      end else begin
         sb = day_serial(p.begin_year, p.begin_month, p.begin_day);
         se = day_serial(p.end_year, p.end_month, p.end_day);
         if (sb >= se) begin
            r.status = ddd_pkg::STATUS_UNORDERED;
         end else begin
            r.status    = ddd_pkg::STATUS_OK;
            r.day_count = ddd_pkg::COUNT_W'(se - sb);
         end
      end
      return r;
   endfunction

   // idle length: mostly none, sometimes a few cycles, rarely long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // valid date, biased toward century and leap years and month ends
   function automatic void random_date(output logic [ddd_pkg::YEAR_W-1:0] y,
                                       output logic [ddd_pkg::MONTH_W-1:0] m,
                                       output logic [ddd_pkg::DAY_W-1:0] d);
      int unsigned len;
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 5))
            0:       y = ddd_pkg::YEAR_MIN;
            1:       y = ddd_pkg::YEAR_MAX;
            2:       y = 14'd2000;
            3:       y = 14'd1900;
            4:       y = ddd_pkg::YEAR_W'($urandom_range(1, 2499) * 4);
            default: y = ddd_pkg::YEAR_W'($urandom_range(1, 99) * 100);
         endcase
      end else begin
         y = ddd_pkg::YEAR_W'($urandom_range(ddd_pkg::YEAR_MIN, ddd_pkg::YEAR_MAX));
      end
      m   = ddd_pkg::MONTH_W'($urandom_range(1, 12));
      len = month_days(y, m);
      d   = ddd_pkg::DAY_W'(($urandom_range(0, 4) == 0) ? len : $urandom_range(1, len));
   endfunction

   // break exactly one field of a pair
   function automatic void corrupt_field(inout date_pair_type p);
      int unsigned len;
      case ($urandom_range(0, 5))
         0: p.begin_year = ($urandom_range(0, 1) == 0) ? '0
                           : ddd_pkg::YEAR_W'($urandom_range(10000, 16383));
         1: p.end_year = ($urandom_range(0, 1) == 0) ? '0
                         : ddd_pkg::YEAR_W'($urandom_range(10000, 16383));
         2: p.begin_month = ($urandom_range(0, 1) == 0) ? '0
                            : ddd_pkg::MONTH_W'($urandom_range(13, 15));
         3: p.end_month = ($urandom_range(0, 1) == 0) ? '0
                          : ddd_pkg::MONTH_W'($urandom_range(13, 15));
         4: begin
            len = month_days(p.begin_year, p.begin_month);
            p.begin_day = (len < 31) ? ddd_pkg::DAY_W'($urandom_range(len + 1, 31)) : '0;
         end
         default: begin
            len = month_days(p.end_year, p.end_month);
            p.end_day = (len < 31) ? ddd_pkg::DAY_W'($urandom_range(len + 1, 31)) : '0;
         end
      endcase
   endfunction

   // mostly well-ordered valid pairs, some broken fields, some raw noise
   function automatic date_pair_type make_random_pair();
      date_pair_type p;
      int unsigned   kind;
      int unsigned   r;
      int unsigned   len;
      int unsigned   near_year;
      kind = $urandom_range(0, 99);
      if (kind < 86) begin
         random_date(p.begin_year, p.begin_month, p.begin_day);
         random_date(p.end_year, p.end_month, p.end_day);
         // sometimes keep the end within a couple of years of the begin
         if ($urandom_range(0, 3) == 0) begin
            near_year = p.begin_year + $urandom_range(0, 2);
            if (near_year > ddd_pkg::YEAR_MAX)
               near_year = ddd_pkg::YEAR_MAX;
            p.end_year = ddd_pkg::YEAR_W'(near_year);
            len = month_days(p.end_year, p.end_month);
            if (p.end_day > len)
               p.end_day = ddd_pkg::DAY_W'(len);
         end
         r = $urandom_range(0, 99);
         if (r < 5) begin
            {p.end_year, p.end_month, p.end_day} = {p.begin_year, p.begin_month, p.begin_day};
         end else if (r < 95 &&
                      day_serial(p.begin_year, p.begin_month, p.begin_day) >
                      day_serial(p.end_year, p.end_month, p.end_day)) begin
            p = {p.end_year, p.end_month, p.end_day, p.begin_year, p.begin_month, p.begin_day};
         end
         if (kind >= 72)
            corrupt_field(p);
      end else begin
         p.begin_year  = ddd_pkg::YEAR_W'($urandom_range(0, 16383));
         p.begin_month = ddd_pkg::MONTH_W'($urandom_range(0, 15));
         p.begin_day   = ddd_pkg::DAY_W'($urandom_range(0, 31));
         p.end_year    = ddd_pkg::YEAR_W'($urandom_range(0, 16383));
         p.end_month   = ddd_pkg::MONTH_W'($urandom_range(0, 15));
         p.end_day     = ddd_pkg::DAY_W'($urandom_range(0, 31));
      end
      return p;
   endfunction

   // offer one pair after an idle gap and log its span once the transaction is taken
   task automatic send_pair(input date_pair_type p, input span_result_type span,
                            input int unsigned gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.begin_year  <= p.begin_year;
      req_chan.begin_month <= p.begin_month;
      req_chan.begin_day   <= p.begin_day;
      req_chan.end_year    <= p.end_year;
      req_chan.end_month   <= p.end_month;
      req_chan.end_day     <= p.end_day;
      do @(posedge clock); while (!req_chan.ready);
      expected_spans.push_back(span);
   endtask

   // request side: reset, directed table, then random pairs
   initial begin : request_source
      date_pair_type pair;
      int unsigned   gap;
      req_chan.valid       <= 1'b0;
      req_chan.begin_year  <= '0;
      req_chan.begin_month <= '0;
      req_chan.begin_day   <= '0;
      req_chan.end_year    <= '0;
      req_chan.end_month   <= '0;
      req_chan.end_day     <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_pair(directed_rows[i].dates,
                   directed_rows[i].typed ? directed_rows[i].span
                                          : predict_span(directed_rows[i].dates),
                   pick_gap());
      end

      // two stretches run back to back, the first overlaps the long response hold
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pair = make_random_pair();
         gap  = ((i >= 100 && i < 260) || (i >= 500 && i < 560)) ? 0 : pick_gap();
         send_pair(pair, predict_span(pair), gap);
      end
      req_chan.valid <= 1'b0;

      while (expected_spans.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d date pairs (%0d directed): %0d ok, %0d invalid date, %0d out of order",
               req_accepts, NUM_DIRECTED, ok_count, invalid_count, unordered_count);
      $display("response side stalled at random and held off once for %0d cycles", HOLD_CYCLES);
      if (mismatches == 0)
         $display("date_difference_days_core_tb: PASS");
      else
         $display("date_difference_days_core_tb: FAIL");
      $finish;
   end

   // response side: random stalls, one long hold while requests keep coming
   initial begin : response_sink
      int unsigned stall;
      bit          held;
      held = 1'b0;
      rsp_chan.ready <= 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (!held && req_accepts >= HOLD_TRIGGER) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_chan.ready <= 1'b1;
            repeat (OPEN_CYCLES) @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // count request transactions
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         req_accepts++;
   end

   // compare each result transaction with the oldest expected span
   always @(posedge clock) begin : span_check
      span_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_spans.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual day_count %0d status %0d",
                     $time, rsp_chan.day_count, rsp_chan.status);
         end else begin
            want = expected_spans.pop_front();
            if (rsp_chan.day_count !== want.day_count) begin
               mismatches++;
               $display("%0t: day_count mismatch, expected %0d, actual %0d",
                        $time, want.day_count, rsp_chan.day_count);
            end
            if (rsp_chan.status !== want.status) begin
               mismatches++;
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_chan.status);
            end
         end
         case (rsp_chan.status)
            ddd_pkg::STATUS_OK:        ok_count++;
            ddd_pkg::STATUS_INVALID:   invalid_count++;
            ddd_pkg::STATUS_UNORDERED: unordered_count++;
            default:                   ;
         endcase
      end
   end

   // watchdog on cycles with no transaction on either side
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no transaction for %0d cycles, %0d spans still expected",
               $time, IDLE_LIMIT, expected_spans.size());
      $display("date_difference_days_core_tb: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ddd_pkg.sv
hdl/ddd_req_if.sv
hdl/ddd_rsp_if.sv
hdl/ddd_year_split.sv
hdl/ddd_serial.sv
hdl/date_difference_days_core.sv
tb/sv/date_difference_days_core_tb.sv
